// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_RST(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Check that a trigger condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_RST(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/pva_pkg.sv -----
`default_nettype none

package pva_pkg;

	// default voice count, range 1 to 64
	localparam int NUM_VOICES_DEF = 8;
	// widest voice index over that range
	localparam int VIDX_W = 6;

	localparam int NOTE_W  = 7;
	localparam int VEL_W   = 7;
	localparam int FV_W    = 3;
	localparam int VOICE_W = 3;
	localparam int SEED_W  = 16;
	localparam int KIND_W  = 2;
	localparam int ACT_W   = 2;

	// stream payload layout
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;
	localparam int VEL_LSB    = VOICE_W + NOTE_W;
	localparam int SEED_MSB   = VEL_LSB + VEL_W + 1 + SEED_W - 1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT = 1'd1;

	// drift seed: low 16 bits of (note + 37) * 0x9E3779B1
	localparam logic [31:0] SEED_MULT    = 32'h9E37_79B1;
	localparam logic [15:0] SEED_MULT_LO = SEED_MULT[15:0];
	localparam logic [15:0] NOTE_BIAS    = 16'd37;

	typedef enum logic [KIND_W-1:0] {
		KIND_ON  = 2'd0,
		KIND_OFF = 2'd1,
		KIND_FIN = 2'd2
	} kind_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_TRIGGER = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_RETIRE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// one voice entry as held in the voice RAM
	typedef struct packed {
		logic              active;
		logic              releasing;
		logic [NOTE_W-1:0] note;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// findings of one pass over the voice RAM
	typedef struct packed {
		logic              idle_found;
		logic [VIDX_W-1:0] idle_idx;
		logic              rel_found;
		logic [VIDX_W-1:0] rel_idx;
		logic              act_found;
		logic [VIDX_W-1:0] act_idx;
		logic              match_found;
		logic [VIDX_W-1:0] match_idx;
		logic              tgt_active;
		logic [NOTE_W-1:0] tgt_note;
	} scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/pva_ram.sv -----
`default_nettype none

module pva_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/pva_scan.sv -----
`default_nettype none

module pva_scan #(
	parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      rd_vld,
	input  wire logic [VW-1:0]             rd_idx,
	input  wire pva_pkg::entry_t           rd_entry,
	input  wire logic [pva_pkg::NOTE_W-1:0] note,
	input  wire logic [pva_pkg::FV_W-1:0]  fv,
	output pva_pkg::scan_res_t             res
);

	pva_pkg::scan_res_t                res_q;
	logic [pva_pkg::VIDX_W-1:0]        idx_w;

	assign idx_w = pva_pkg::VIDX_W'(rd_idx);
	assign res   = res_q;

	// keep the lowest index of each kind of voice seen so far, and capture the entry at index fv
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (start) begin
			res_q <= '0;
		end else if (rd_vld) begin
			if (!rd_entry.active && !res_q.idle_found) begin
				res_q.idle_found <= 1'b1;
				res_q.idle_idx   <= idx_w;
			end
			if (rd_entry.releasing && !res_q.rel_found) begin
				res_q.rel_found <= 1'b1;
				res_q.rel_idx   <= idx_w;
			end
			if (rd_entry.active && !res_q.act_found) begin
				res_q.act_found <= 1'b1;
				res_q.act_idx   <= idx_w;
			end
			if (rd_entry.active && !rd_entry.releasing && rd_entry.note == note
					&& !res_q.match_found) begin
				res_q.match_found <= 1'b1;
				res_q.match_idx   <= idx_w;
			end
			if (idx_w == pva_pkg::VIDX_W'(fv)) begin
				res_q.tgt_active <= rd_entry.active;
				res_q.tgt_note   <= rd_entry.note;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/poly_voice_allocator.sv -----
`default_nettype none

// Channel   Dir  Beat fields (low bit up)
// cfg       in   cfg_index: 0 mono_mode, 1 drift_on; cfg_data: value bit
// s_axis    in   tuser: kind; tdata: note, velocity, finished_voice
// m_axis    out  tuser: action; tdata: voice, voice_note, voice_velocity,
//                stolen, drift_seed
//
// Each event passes through the scan state, one read per voice over the single RAM
// read port, the drain state for the last read, and the done state, which decides,
// loads the result and writes back. The next event is taken only after the load.
// While m_axis stalls a held result, the done state waits, so the write back and the
// next event stall with it. Reset clears the per-voice valid bits, so voices read as
// idle with note 0 and no clearing pass is run.

module poly_voice_allocator #(
	parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pva_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pva_pkg::CFG_DATA_W-1:0]     cfg_data,
	// event stream in
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// note [6:0], velocity [13:7], finished_voice [16:14], zero fill above
	input  wire logic [pva_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// kind [1:0]
	input  wire logic [pva_pkg::KIND_W-1:0]         s_axis_tuser,
	// result stream out
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// voice [2:0], voice_note [9:3], voice_velocity [16:10], stolen [17],
	// drift_seed [33:18], zero fill above
	output logic [pva_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// action [1:0]
	output logic [pva_pkg::ACT_W-1:0]               m_axis_tuser
);

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VOICES - 1);

	// configuration registers
	logic mono_q;
	logic drift_q;

	// latched event
	logic [pva_pkg::KIND_W-1:0] kind_q;
	logic [pva_pkg::NOTE_W-1:0] note_q;
	logic [pva_pkg::VEL_W-1:0]  vel_q;
	logic [pva_pkg::FV_W-1:0]   fv_q;
	logic [pva_pkg::SEED_W-1:0] seed_q;

	pva_pkg::state_t state_q, state_d;
	logic [VW-1:0]   cnt_q;

	// read pipeline
	logic            rd_issue;
	logic            rd_vld_s1;
	logic [VW-1:0]   rd_idx_s1;
	logic [pva_pkg::ENTRY_W-1:0] ram_rdata;
	pva_pkg::entry_t rd_entry;
	logic [NUM_VOICES-1:0] valid_q;

	pva_pkg::scan_res_t scan_res;

	// decision and write back
	logic            in_acc;
	logic            out_free;
	logic            out_load;
	logic            wr_req;
	logic            wr_en;
	logic [pva_pkg::VIDX_W-1:0] wr_idx;
	pva_pkg::entry_t wr_entry;
	pva_pkg::action_t res_act;
	logic [pva_pkg::NOTE_W-1:0] res_note;
	logic [pva_pkg::VEL_W-1:0]  res_vel;
	logic            res_stolen;
	logic [pva_pkg::SEED_W-1:0] res_seed;
	logic            fv_in_range;
	logic            is_off;

	// output register
	logic                         m_valid_q;
	pva_pkg::action_t             m_act_q;
	logic [pva_pkg::VOICE_W-1:0]  m_voice_q;
	logic [pva_pkg::NOTE_W-1:0]   m_note_q;
	logic [pva_pkg::VEL_W-1:0]    m_vel_q;
	logic                         m_stolen_q;
	logic [pva_pkg::SEED_W-1:0]   m_seed_q;

	assign cfg_ready = (state_q == pva_pkg::ST_IDLE);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;

	// configuration writes, taken only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q  <= 1'b0;
			drift_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pva_pkg::CFG_MONO:  mono_q  <= cfg_data[0];
				pva_pkg::CFG_DRIFT: drift_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold the event for the whole pass
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= s_axis_tuser;
			note_q <= s_axis_tdata[pva_pkg::NOTE_W-1:0];
			vel_q  <= s_axis_tdata[pva_pkg::NOTE_W +: pva_pkg::VEL_W];
			fv_q   <= s_axis_tdata[pva_pkg::NOTE_W + pva_pkg::VEL_W +: pva_pkg::FV_W];
		end
		// low 16 bits of the product need only the low 16 bits of the multiplier
		seed_q <= (pva_pkg::SEED_W'(note_q) + pva_pkg::NOTE_BIAS) * pva_pkg::SEED_MULT_LO;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pva_pkg::ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (rd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pva_pkg::ST_IDLE:  if (in_acc) state_d = pva_pkg::ST_SCAN;
			pva_pkg::ST_SCAN:  if (cnt_q == LAST_IDX) state_d = pva_pkg::ST_DRAIN;
			pva_pkg::ST_DRAIN: state_d = pva_pkg::ST_DONE;
			pva_pkg::ST_DONE:  if (out_free) state_d = pva_pkg::ST_IDLE;
			default:           state_d = pva_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_issue      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			pva_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pva_pkg::ST_SCAN: rd_issue      = 1'b1;
			pva_pkg::ST_DONE: out_load      = out_free;
			default: ;
		endcase
	end

	// voice store
	pva_ram #(
		.WIDTH (pva_pkg::ENTRY_W),
		.DEPTH (NUM_VOICES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx[VW-1:0]),
		.wdata (wr_entry),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// a voice never written reads as idle with note 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx[VW-1:0]] <= 1'b1;
		end
	end

	assign rd_entry = valid_q[rd_idx_s1] ? pva_pkg::entry_t'(ram_rdata) : '0;

	pva_scan #(
		.NUM_VOICES (NUM_VOICES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.rd_vld   (rd_vld_s1),
		.rd_idx   (rd_idx_s1),
		.rd_entry (rd_entry),
		.note     (note_q),
		.fv       (fv_q),
		.res      (scan_res)
	);

	assign fv_in_range = int'(fv_q) < NUM_VOICES;
	assign is_off = (kind_q == pva_pkg::KIND_OFF) ||
		(kind_q == pva_pkg::KIND_ON && vel_q == '0);

	// pick the voice and the write back from the pass findings
	always_comb begin
		wr_req     = 1'b0;
		wr_idx     = '0;
		wr_entry   = '0;
		res_act    = pva_pkg::ACT_NONE;
		res_note   = '0;
		res_vel    = '0;
		res_stolen = 1'b0;
		res_seed   = '0;
		if (kind_q == pva_pkg::KIND_ON && !is_off) begin
			if (mono_q) begin
				// reuse the lowest active voice, else voice 0
				wr_idx     = scan_res.act_found ? scan_res.act_idx : '0;
				res_stolen = scan_res.act_found;
			end else if (scan_res.idle_found) begin
				wr_idx     = scan_res.idle_idx;
			end else if (scan_res.rel_found) begin
				wr_idx     = scan_res.rel_idx;
				res_stolen = 1'b1;
			end else begin
				wr_idx     = scan_res.act_idx;
				res_stolen = 1'b1;
			end
			wr_req             = 1'b1;
			wr_entry.active    = 1'b1;
			wr_entry.releasing = 1'b0;
			wr_entry.note      = note_q;
			res_act            = pva_pkg::ACT_TRIGGER;
			res_note           = note_q;
			res_vel            = vel_q;
			res_seed           = drift_q ? seed_q : '0;
		end else if (is_off) begin
			if (scan_res.match_found) begin
				wr_req             = 1'b1;
				wr_idx             = scan_res.match_idx;
				wr_entry.active    = 1'b1;
				wr_entry.releasing = 1'b1;
				wr_entry.note      = note_q;
				res_act            = pva_pkg::ACT_RELEASE;
				res_note           = note_q;
			end
		end else if (kind_q == pva_pkg::KIND_FIN) begin
			if (fv_in_range && scan_res.tgt_active) begin
				// drop both flags, keep the stored note
				wr_req        = 1'b1;
				wr_idx        = pva_pkg::VIDX_W'(fv_q);
				wr_entry.note = scan_res.tgt_note;
				res_act       = pva_pkg::ACT_RETIRE;
				res_note      = scan_res.tgt_note;
			end
		end
	end

	assign wr_en = wr_req && out_load;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_act_q    <= res_act;
			m_voice_q  <= res_act == pva_pkg::ACT_NONE ? '0 : pva_pkg::VOICE_W'(wr_idx);
			m_note_q   <= res_note;
			m_vel_q    <= res_vel;
			m_stolen_q <= res_stolen;
			m_seed_q   <= res_seed;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_act_q;
	assign m_axis_tdata  = {6'd0, m_seed_q, m_stolen_q, m_vel_q, m_note_q, m_voice_q};

endmodule

`default_nettype wire

// ----- rtl/core/pva_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module pva_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [pva_pkg::ACT_W-1:0]     m_axis_tuser
);

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

	// one event in flight: no second beat right after an accepted one
	`ASSERT_NEXT(a_one_inflight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "event taken while another is in work")

	// an event with no action reports all zero
	`ASSERT_IMPL(a_none_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == pva_pkg::ACT_NONE, m_axis_tdata == '0, "no-action result carries data")

	// releases and retirements carry no velocity, steal flag or seed
	`ASSERT_IMPL(a_rel_clean, clk, arst_n, m_axis_tvalid && (m_axis_tuser == pva_pkg::ACT_RELEASE || m_axis_tuser == pva_pkg::ACT_RETIRE), m_axis_tdata[pva_pkg::SEED_MSB:pva_pkg::VEL_LSB] == '0, "release or retire result has trigger fields set")

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (.*);

`default_nettype wire
